@@ sv/ptc_pkg.sv @@
// shared types and constants for the pressure/temperature compensation pipeline
`default_nettype none

package ptc_pkg;

  // register indexes, taken from paddr[4:2]
  localparam logic [2:0] REG_C1 = 3'd0;
  localparam logic [2:0] REG_C2 = 3'd1;
  localparam logic [2:0] REG_C3 = 3'd2;
  localparam logic [2:0] REG_C4 = 3'd3;
  localparam logic [2:0] REG_C5 = 3'd4;
  localparam logic [2:0] REG_C6 = 3'd5;

  // scaling
  localparam int TEMP_SHIFT    = 23;
  localparam int OFF_TC_SHIFT  = 7;
  localparam int SENS_TC_SHIFT = 8;
  localparam int T2_LOW_SHIFT  = 33;
  localparam int T2_HIGH_SHIFT = 37;
  localparam int SENS_SHIFT    = 21;
  localparam int PRES_SHIFT    = 15;

  // 20.00 C and the distance from 20.00 C down to -15.00 C
  localparam logic signed [19:0] T_REF_CENTI  = 20'sd2000;
  localparam logic signed [19:0] T_LOW_OFFSET = 20'sd3500;

  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
  } ptc_cal_t;

  // compensated terms handed from the temperature path to the pressure path
  typedef struct packed {
    logic signed [20:0] temp;
    logic signed [41:0] off;
    logic signed [41:0] sens;
    logic        [23:0] d1;
  } ptc_comp_t;

endpackage

`default_nettype wire

@@ sv/ptc_cfg_regs.sv @@
// apb register file holding the six calibration words
`default_nettype none

module ptc_cfg_regs (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output ptc_pkg::ptc_cal_t      cal_o
);
  import ptc_pkg::*;

  ptc_cal_t   cal_q, cal_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_comb begin
    cal_d = cal_q;
    if (wr_en) begin
      case (reg_idx)
        REG_C1:  cal_d.c1 = pwdata[15:0];
        REG_C2:  cal_d.c2 = pwdata[15:0];
        REG_C3:  cal_d.c3 = pwdata[15:0];
        REG_C4:  cal_d.c4 = pwdata[15:0];
        REG_C5:  cal_d.c5 = pwdata[15:0];
        REG_C6:  cal_d.c6 = pwdata[15:0];
        default: cal_d = cal_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_C1:  prdata = {16'h0, cal_q.c1};
      REG_C2:  prdata = {16'h0, cal_q.c2};
      REG_C3:  prdata = {16'h0, cal_q.c3};
      REG_C4:  prdata = {16'h0, cal_q.c4};
      REG_C5:  prdata = {16'h0, cal_q.c5};
      REG_C6:  prdata = {16'h0, cal_q.c6};
      default: prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule

`default_nettype wire

@@ sv/ptc_temp_path.sv @@
// five-stage pipeline: dT, products, first-order terms, squares, second-order correction
`default_nettype none

module ptc_temp_path (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [23:0]       raw_temperature_i,
  input  wire logic [23:0]       raw_pressure_i,
  input  wire ptc_pkg::ptc_cal_t cal_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output ptc_pkg::ptc_comp_t     comp_o
);
  import ptc_pkg::*;

  localparam int NSTG = 5;

  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   en;

  // stage enables ripple back so bubbles are squeezed out
  always_comb begin
    en[NSTG] = ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 1: dT = D2 - C5*2^8
  logic signed [24:0] dt_q, dt_d;
  logic        [23:0] d1_s1_q;

  assign dt_d = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, cal_i.c5, 8'h00});

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dt_q    <= dt_d;
      d1_s1_q <= raw_pressure_i;
    end
  end

  // stage 2: products with dT
  logic signed [41:0] prod_t_q, pc4_q, pc3_q;
  logic signed [49:0] dt_sq;
  logic        [47:0] dt2_q;
  logic        [23:0] d1_s2_q;

  assign dt_sq = dt_q * dt_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      prod_t_q <= dt_q * $signed({1'b0, cal_i.c6});
      pc4_q    <= dt_q * $signed({1'b0, cal_i.c4});
      pc3_q    <= dt_q * $signed({1'b0, cal_i.c3});
      dt2_q    <= dt_sq[47:0];
      d1_s2_q  <= d1_s1_q;
    end
  end

  // stage 3: first-order temperature, offset, sensitivity and T2
  logic signed [41:0] prod_sh, pc4_sh, pc3_sh;
  logic signed [18:0] dev_d, dev_q;
  logic signed [19:0] temp1_d, temp1_q, lo_d, lo_q;
  logic signed [35:0] off1_d, off1_q, sens1_d, sens1_q;
  logic        [16:0] t2_lo, t2_d, t2_q;
  logic        [50:0] dt2_x7;
  logic               low_q, vlow_q;
  logic        [23:0] d1_s3_q;

  always_comb begin
    prod_sh = prod_t_q >>> TEMP_SHIFT;
    pc4_sh  = pc4_q >>> OFF_TC_SHIFT;
    pc3_sh  = pc3_q >>> SENS_TC_SHIFT;
    dev_d   = $signed(prod_sh[18:0]);
    temp1_d = $signed({dev_d[18], dev_d}) + T_REF_CENTI;
    lo_d    = $signed({dev_d[18], dev_d}) + T_LOW_OFFSET;
    off1_d  = $signed({4'h0, cal_i.c2, 16'h0000}) + $signed(pc4_sh[35:0]);
    sens1_d = $signed({5'h00, cal_i.c1, 15'h0000}) + $signed(pc3_sh[35:0]);
    t2_lo   = {2'b00, dt2_q[47:T2_LOW_SHIFT]} * 17'd3;
    dt2_x7  = {3'b000, dt2_q} * 51'd7;
    // below 20.00 C exactly when the first-order deviation is negative
    t2_d    = dev_d[18] ? t2_lo : {3'b000, dt2_x7[50:T2_HIGH_SHIFT]};
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      dev_q   <= dev_d;
      temp1_q <= temp1_d;
      lo_q    <= lo_d;
      off1_q  <= off1_d;
      sens1_q <= sens1_d;
      t2_q    <= t2_d;
      low_q   <= dev_d[18];
      vlow_q  <= lo_d[19];
      d1_s3_q <= d1_s2_q;
    end
  end

  // stage 4: squared deviations
  logic signed [37:0] dev_sq;
  logic signed [39:0] lo_sq;
  logic        [35:0] dev2_q, lo2_q;
  logic signed [19:0] temp1_s4_q;
  logic signed [35:0] off1_s4_q, sens1_s4_q;
  logic        [16:0] t2_s4_q;
  logic               low_s4_q, vlow_s4_q;
  logic        [23:0] d1_s4_q;

  assign dev_sq = dev_q * dev_q;
  assign lo_sq  = lo_q * lo_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      dev2_q     <= dev_sq[35:0];
      lo2_q      <= lo_sq[35:0];
      temp1_s4_q <= temp1_q;
      off1_s4_q  <= off1_q;
      sens1_s4_q <= sens1_q;
      t2_s4_q    <= t2_q;
      low_s4_q   <= low_q;
      vlow_s4_q  <= vlow_q;
      d1_s4_q    <= d1_s3_q;
    end
  end

  // stage 5: second-order offset and sensitivity, final temperature
  logic [39:0] dev2_x, lo2_x, off2, sens2;
  ptc_comp_t   comp_d, comp_q;

  always_comb begin
    dev2_x = {4'h0, dev2_q};
    lo2_x  = {4'h0, lo2_q};
    if (low_s4_q) begin
      off2  = ((dev2_x * 40'd3) >> 1) + (vlow_s4_q ? lo2_x * 40'd7 : 40'd0);
      sens2 = ((dev2_x * 40'd5) >> 3) + (vlow_s4_q ? lo2_x << 2 : 40'd0);
    end else begin
      off2  = dev2_x >> 4;
      sens2 = 40'd0;
    end
    comp_d.temp = $signed({temp1_s4_q[19], temp1_s4_q}) - $signed({4'h0, t2_s4_q});
    comp_d.off  = $signed({{6{off1_s4_q[35]}}, off1_s4_q}) - $signed({2'b00, off2});
    comp_d.sens = $signed({{6{sens1_s4_q[35]}}, sens1_s4_q}) - $signed({2'b00, sens2});
    comp_d.d1   = d1_s4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      comp_q <= comp_d;
    end
  end

  assign comp_o = comp_q;

endmodule

`default_nettype wire

@@ sv/ptc_pres_path.sv @@
// three-stage pipeline: split product D1*SENS, scale by 2^21, subtract OFF and scale by 2^15
`default_nettype none

module ptc_pres_path (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire ptc_pkg::ptc_comp_t comp_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic [31:0]             temperature_centi_o,
  output logic [31:0]             pressure_value_o
);
  import ptc_pkg::*;

  localparam int NSTG = 3;

  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   en;

  always_comb begin
    en[NSTG] = ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 6: SENS split into a signed upper and unsigned lower half
  logic        [44:0] p_lo_q;
  logic signed [45:0] p_hi_q;
  logic signed [41:0] off_s6_q;
  logic signed [20:0] temp_s6_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p_lo_q    <= {24'h0, comp_i.sens[20:0]} * {21'h0, comp_i.d1};
      p_hi_q    <= $signed(comp_i.sens[41:21]) * $signed({1'b0, comp_i.d1});
      off_s6_q  <= comp_i.off;
      temp_s6_q <= comp_i.temp;
    end
  end

  // stage 7: recombine and divide by 2^21 toward zero
  logic signed [63:0] full_sum, scaled;
  logic signed [63:0] bias21;
  logic signed [42:0] q_q;
  logic signed [41:0] off_s7_q;
  logic signed [20:0] temp_s7_q;

  always_comb begin
    // the product is negative only when the upper half is
    bias21   = p_hi_q[45] ? 64'sd2097151 : 64'sd0;
    full_sum = $signed({p_hi_q[42:0], 21'h000000}) + $signed({19'h00000, p_lo_q}) + bias21;
    scaled   = full_sum >>> SENS_SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      q_q       <= scaled[42:0];
      off_s7_q  <= off_s6_q;
      temp_s7_q <= temp_s6_q;
    end
  end

  // stage 8: subtract OFF, divide by 2^15 toward zero, wrap to 32 bits
  logic signed [43:0] diff, diff_b, p_sh;
  logic        [31:0] pres_q, temp_q;

  always_comb begin
    diff   = $signed({q_q[42], q_q}) - $signed({{2{off_s7_q[41]}}, off_s7_q});
    diff_b = diff + (diff[43] ? 44'sd32767 : 44'sd0);
    p_sh   = diff_b >>> PRES_SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      pres_q <= p_sh[31:0];
      temp_q <= {{11{temp_s7_q[20]}}, temp_s7_q};
    end
  end

  assign temperature_centi_o = temp_q;
  assign pressure_value_o    = pres_q;

endmodule

`default_nettype wire

@@ sv/pressure_temp_compensation_unit.sv @@
// Second-order temperature compensation of a pressure sensor, top level.
//   s_axis: one transaction carries a raw pair, tdata[23:0] raw temperature (D2),
//           tdata[47:24] raw pressure (D1).
//   m_axis: one transaction per input, tdata[31:0] compensated temperature in
//           0.01 C, tdata[63:32] compensated pressure, both signed.
//   apb:    calibration words C1..C6 at byte addresses 0x00..0x14, low 16 bits.
//           Write them only while no transaction is in flight.
// Throughput is one transaction per cycle while m_axis_tready is high. On its
// way to m_axis a transaction passes five register stages in the temperature
// path (dT, products, first-order terms, squares, second-order terms) and three
// in the pressure path (split 42x24 product, scale by 2^21, scale by 2^15).
// Each stage carries a valid bit and holds while its successor is full and
// stalled, so a stall on m_axis_tready fills empty stages first and only then
// drops s_axis_tready; nothing is lost or repeated.
// Reset clears all valid bits and the calibration words to zero.
`default_nettype none

module pressure_temp_compensation_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // raw_temperature, raw_pressure
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // temperature_centi, pressure_value
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import ptc_pkg::*;

  ptc_cal_t    cal;
  ptc_comp_t   comp;
  logic        comp_valid;
  logic        comp_ready;
  logic [31:0] temperature_centi;
  logic [31:0] pressure_value;

  ptc_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cal_o   (cal)
  );

  ptc_temp_path u_temp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (s_axis_tvalid),
    .ready_o           (s_axis_tready),
    .raw_temperature_i (s_axis_tdata[23:0]),
    .raw_pressure_i    (s_axis_tdata[47:24]),
    .cal_i             (cal),
    .valid_o           (comp_valid),
    .ready_i           (comp_ready),
    .comp_o            (comp)
  );

  ptc_pres_path u_pres (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (comp_valid),
    .ready_o             (comp_ready),
    .comp_i              (comp),
    .valid_o             (m_axis_tvalid),
    .ready_i             (m_axis_tready),
    .temperature_centi_o (temperature_centi),
    .pressure_value_o    (pressure_value)
  );

  assign m_axis_tdata = {pressure_value, temperature_centi};

endmodule

`default_nettype wire
